// File: src/atc_pkg.sv
package atc_pkg;

  // Fixed field widths
  localparam int CfgW     = 7;   // node_count register
  localparam int OutNodeW = 6;   // first_isolated_node

  // Default matrix size limit
  localparam int MaxNodes = 64;

  // Walk sequencer states
  typedef enum logic [2:0] {
    WK_IDLE,
    WK_INIT,
    WK_FETCH,
    WK_SCAN,
    WK_POP,
    WK_POPD,
    WK_DONE
  } atc_wstate_t;

  // Load/check unit status toward the top level
  typedef struct packed {
    logic                start;   // last entry of a matrix taken this cycle
    logic                iso;
    logic [OutNodeW-1:0] first;
    logic                notadj;
  } atc_chk_t;

  // Walk status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic cycle;
  } atc_walk_t;

endpackage

// File: src/atc_ram.sv
// Simple dual-port RAM, one write and one registered read port
module atc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/atc_load.sv
// Matrix load: assembles rows, writes them to the work RAM and runs the
// empty-row, diagonal and symmetry checks on the fly.
module atc_load #(
  parameter int MAX_NODES = atc_pkg::MaxNodes
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         entry,
  input  logic                         restart,
  input  logic [$clog2(MAX_NODES)-1:0] n_last,
  output logic                         wr_en,
  output logic [$clog2(MAX_NODES)-1:0] wr_addr,
  output logic [MAX_NODES-1:0]         wr_data,
  output logic                         rd_en,
  output logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic [MAX_NODES-1:0]         rd_data,
  output atc_pkg::atc_chk_t            chk
);

  localparam int NodeW = $clog2(MAX_NODES);

  logic [NodeW-1:0]     row;
  logic [NodeW-1:0]     col;
  logic [MAX_NODES-1:0] row_acc;
  logic                 cmp_pend;
  logic                 cmp_bit;
  logic [NodeW-1:0]     cmp_pos;
  logic                 iso, iso_next;
  logic [NodeW-1:0]     first, first_next;
  logic                 notadj, notadj_next;

  logic [MAX_NODES-1:0] col_bit;
  logic [MAX_NODES-1:0] row_val;
  logic                 row_end;
  logic                 mat_end;
  logic                 mat_begin;

  // Row assembly
  assign col_bit   = MAX_NODES'(entry) << col;
  assign row_val   = ((col == '0) ? '0 : row_acc) | col_bit;
  assign row_end   = (col == n_last);
  assign mat_end   = row_end && (row == n_last);
  assign mat_begin = (row == '0) && (col == '0);

  // Full row goes to RAM on its last column
  assign wr_en   = accept && row_end;
  assign wr_addr = row;
  assign wr_data = row_val;

  // Below the diagonal: fetch the mirror row and compare it in the next cycle
  assign rd_en   = accept && (col < row);
  assign rd_addr = col;

  // Check accumulators
  always_comb begin
    iso_next    = iso;
    first_next  = first;
    notadj_next = notadj;
    if (cmp_pend && (rd_data[cmp_pos] != cmp_bit)) begin
      notadj_next = 1'b1;
    end
    if (accept) begin
      if (mat_begin) begin
        iso_next    = 1'b0;
        first_next  = '0;
        notadj_next = 1'b0;
      end
      if ((row == col) && entry) begin
        notadj_next = 1'b1;
      end
      if (row_end && (row_val == '0) && !iso_next) begin
        iso_next   = 1'b1;
        first_next = row;
      end
    end
  end

  // Position counters and check state
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      cmp_pend <= 1'b0;
      iso      <= 1'b0;
      first    <= '0;
      notadj   <= 1'b0;
    end else begin
      iso      <= iso_next;
      first    <= first_next;
      notadj   <= notadj_next;
      cmp_pend <= rd_en;
      if (restart) begin
        row <= '0;
        col <= '0;
      end else if (accept) begin
        if (row_end) begin
          col <= '0;
          row <= mat_end ? '0 : row + NodeW'(1);
        end else begin
          col <= col + NodeW'(1);
        end
      end
    end
  end

  // Beat payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      row_acc <= row_val;
      cmp_bit <= entry;
      cmp_pos <= row;
    end
  end

  assign chk.start  = accept && mat_end;
  assign chk.iso    = iso;
  assign chk.first  = atc_pkg::OutNodeW'(first);
  assign chk.notadj = notadj;

endmodule

// File: src/atc_walk.sv
// Depth-first walk from node 0 over the work RAM. Row bits are scanned one
// per cycle; each new child is pushed and its back edge cleared by a
// read-modify-write of the child's row, pipelined behind the scan.
module atc_walk #(
  parameter int MAX_NODES = atc_pkg::MaxNodes
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             done_ack,
  input  logic [$clog2(MAX_NODES)-1:0]     n_last,
  output logic                             wr_en,
  output logic [$clog2(MAX_NODES)-1:0]     wr_addr,
  output logic [MAX_NODES-1:0]             wr_data,
  output logic                             rd_en,
  output logic [$clog2(MAX_NODES)-1:0]     rd_addr,
  input  logic [MAX_NODES-1:0]             rd_data,
  output logic                             s_wr_en,
  output logic [$clog2(MAX_NODES+1)-1:0]   s_wr_addr,
  output logic [$clog2(MAX_NODES)-1:0]     s_wr_data,
  output logic                             s_rd_en,
  output logic [$clog2(MAX_NODES+1)-1:0]   s_rd_addr,
  input  logic [$clog2(MAX_NODES)-1:0]     s_rd_data,
  output atc_pkg::atc_walk_t               status
);

  localparam int NodeW      = $clog2(MAX_NODES);
  localparam int StackDepth = MAX_NODES + 1;
  localparam int StkAW      = $clog2(StackDepth);
  localparam int LvlW       = $clog2(StackDepth + 1);

  atc_pkg::atc_wstate_t state, state_next;

  logic [NodeW-1:0]     cur;
  logic [NodeW-1:0]     idx;
  logic [MAX_NODES-1:0] scan_row;
  logic [MAX_NODES-1:0] visited;
  logic [LvlW-1:0]      level;
  logic                 pend_v;
  logic [NodeW-1:0]     pend_row;
  logic                 found;

  logic                 take;
  logic                 vis_here;
  logic                 push;
  logic [MAX_NODES-1:0] cur_mask;

  assign cur_mask = MAX_NODES'(1) << cur;
  assign vis_here = visited[idx];
  assign take     = (state == atc_pkg::WK_SCAN) && (idx != cur) && scan_row[idx];
  assign push     = take && !vis_here && (level < LvlW'(StackDepth));

  // Back-edge clear: child row read last cycle, written back now
  assign wr_en   = pend_v;
  assign wr_addr = pend_row;
  assign wr_data = rd_data & ~cur_mask;

  // Stack push
  assign s_wr_en   = push;
  assign s_wr_addr = StkAW'(level);
  assign s_wr_data = idx;

  // Next state and memory reads
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    s_rd_en    = 1'b0;
    s_rd_addr  = StkAW'(level - LvlW'(1));
    case (state)
      atc_pkg::WK_IDLE: begin
        if (start) begin
          state_next = atc_pkg::WK_INIT;
        end
      end
      atc_pkg::WK_INIT: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = atc_pkg::WK_FETCH;
      end
      atc_pkg::WK_FETCH: begin
        state_next = atc_pkg::WK_SCAN;
      end
      atc_pkg::WK_SCAN: begin
        if (take && vis_here) begin
          state_next = atc_pkg::WK_DONE;
        end else begin
          if (take) begin
            rd_en   = 1'b1;
            rd_addr = idx;
          end
          if (idx == n_last) begin
            state_next = atc_pkg::WK_POP;
          end
        end
      end
      atc_pkg::WK_POP: begin
        if (level == '0) begin
          state_next = atc_pkg::WK_DONE;
        end else begin
          s_rd_en    = 1'b1;
          state_next = atc_pkg::WK_POPD;
        end
      end
      atc_pkg::WK_POPD: begin
        rd_en      = 1'b1;
        rd_addr    = s_rd_data;
        state_next = atc_pkg::WK_FETCH;
      end
      atc_pkg::WK_DONE: begin
        if (done_ack) begin
          state_next = atc_pkg::WK_IDLE;
        end
      end
      default: begin
        state_next = atc_pkg::WK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atc_pkg::WK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v  <= 1'b0;
      found   <= 1'b0;
      visited <= '0;
      level   <= '0;
    end else begin
      pend_v <= take && !vis_here;
      case (state)
        atc_pkg::WK_INIT: begin
          found   <= 1'b0;
          visited <= '0;
          level   <= '0;
        end
        atc_pkg::WK_SCAN: begin
          if (take) begin
            if (vis_here) begin
              found <= 1'b1;
            end else begin
              visited[idx] <= 1'b1;
            end
          end
          if (push) begin
            level <= level + LvlW'(1);
          end
        end
        atc_pkg::WK_POP: begin
          if (level != '0) begin
            level <= level - LvlW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scan datapath, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      pend_row <= idx;
    end
    case (state)
      atc_pkg::WK_INIT: begin
        cur <= '0;
      end
      atc_pkg::WK_POPD: begin
        cur <= s_rd_data;
      end
      atc_pkg::WK_FETCH: begin
        scan_row <= rd_data;
        idx      <= '0;
      end
      atc_pkg::WK_SCAN: begin
        idx <= idx + NodeW'(1);
      end
      default: begin
      end
    endcase
  end

  assign status.busy  = (state != atc_pkg::WK_IDLE);
  assign status.done  = (state == atc_pkg::WK_DONE);
  assign status.cycle = found;

endmodule

// File: src/adjacency_tree_check.sv
// Channel   Direction  Signals                         Beat
// -------   ---------  ------------------------------  ---------------------------------
// cfg       in         cfg_valid/cfg_ready, cfg_data   node_count write, restarts load
// in        in         in_valid/in_ready, entry_bit    one matrix entry, row-major
// out       out        out_valid/out_ready, 4 fields   one result per complete matrix
//
// Loading takes one entry per cycle while the walk is idle; the row checks run
// alongside the load. After the last entry the walk scans the row of every node
// it expands, one row bit per cycle, and then hands off its result.
// Reset is synchronous; the RAMs are not cleared since every row is written
// before it is read. in_ready is low while the walk runs, and the walk holds
// its result while the output register is still full.
module adjacency_tree_check #(
  parameter int MAX_NODES = atc_pkg::MaxNodes
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [atc_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        entry_bit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        has_isolated,
  output logic [atc_pkg::OutNodeW-1:0] first_isolated_node,
  output logic                        not_adjacency,
  output logic                        has_cycle
);

  localparam int NodeW = $clog2(MAX_NODES);
  localparam int StkD  = MAX_NODES + 1;
  localparam int StkAW = $clog2(StkD);
  localparam int CfgW  = atc_pkg::CfgW;

  logic [CfgW-1:0]  node_count;
  logic [CfgW-1:0]  n_clamp;
  logic [NodeW-1:0] n_last;
  logic             cfg_we;
  logic             in_acc;
  logic             out_free;
  logic             done_ack;

  atc_pkg::atc_chk_t  chk;
  atc_pkg::atc_walk_t wst;

  // Work RAM ports
  logic                 ld_wr_en, wk_wr_en, m_wr_en;
  logic [NodeW-1:0]     ld_wr_addr, wk_wr_addr, m_wr_addr;
  logic [MAX_NODES-1:0] ld_wr_data, wk_wr_data, m_wr_data;
  logic                 ld_rd_en, wk_rd_en, m_rd_en;
  logic [NodeW-1:0]     ld_rd_addr, wk_rd_addr, m_rd_addr;
  logic [MAX_NODES-1:0] m_rd_data;

  // Stack RAM ports
  logic             s_wr_en, s_rd_en;
  logic [StkAW-1:0] s_wr_addr, s_rd_addr;
  logic [NodeW-1:0] s_wr_data, s_rd_data;

  // Configuration register
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CfgW'(2);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // Node count limited to 2..MAX_NODES
  always_comb begin
    if (node_count < CfgW'(2)) begin
      n_clamp = CfgW'(2);
    end else if (node_count > CfgW'(MAX_NODES)) begin
      n_clamp = CfgW'(MAX_NODES);
    end else begin
      n_clamp = node_count;
    end
  end
  assign n_last = NodeW'(n_clamp - CfgW'(1));

  // Input handshake
  assign in_ready = !wst.busy;
  assign in_acc   = in_valid && in_ready;

  atc_load #(
    .MAX_NODES(MAX_NODES)
  ) u_load (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_acc),
    .entry   (entry_bit),
    .restart (cfg_we),
    .n_last  (n_last),
    .wr_en   (ld_wr_en),
    .wr_addr (ld_wr_addr),
    .wr_data (ld_wr_data),
    .rd_en   (ld_rd_en),
    .rd_addr (ld_rd_addr),
    .rd_data (m_rd_data),
    .chk     (chk)
  );

  atc_walk #(
    .MAX_NODES(MAX_NODES)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (chk.start),
    .done_ack  (done_ack),
    .n_last    (n_last),
    .wr_en     (wk_wr_en),
    .wr_addr   (wk_wr_addr),
    .wr_data   (wk_wr_data),
    .rd_en     (wk_rd_en),
    .rd_addr   (wk_rd_addr),
    .rd_data   (m_rd_data),
    .s_wr_en   (s_wr_en),
    .s_wr_addr (s_wr_addr),
    .s_wr_data (s_wr_data),
    .s_rd_en   (s_rd_en),
    .s_rd_addr (s_rd_addr),
    .s_rd_data (s_rd_data),
    .status    (wst)
  );

  // Work RAM owned by the loader when idle, by the walk otherwise
  assign m_wr_en   = wst.busy ? wk_wr_en   : ld_wr_en;
  assign m_wr_addr = wst.busy ? wk_wr_addr : ld_wr_addr;
  assign m_wr_data = wst.busy ? wk_wr_data : ld_wr_data;
  assign m_rd_en   = wst.busy ? wk_rd_en   : ld_rd_en;
  assign m_rd_addr = wst.busy ? wk_rd_addr : ld_rd_addr;

  atc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_work_ram (
    .clk     (clk),
    .wr_en   (m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (m_wr_data),
    .rd_en   (m_rd_en),
    .rd_addr (m_rd_addr),
    .rd_data (m_rd_data)
  );

  atc_ram #(
    .WIDTH (NodeW),
    .DEPTH (StkD)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (s_rd_data)
  );

  // Output register
  assign out_free = !out_valid || out_ready;
  assign done_ack = wst.done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ack) begin
      has_isolated        <= chk.iso;
      first_isolated_node <= chk.first;
      not_adjacency       <= chk.notadj;
      has_cycle           <= wst.cycle;
    end
  end

  // The last entry of a matrix never lands while a walk is running
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    chk.start |-> !wst.busy)
    else $error("matrix completed during walk");

  // Every completed matrix launches the walk
  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    chk.start |=> wst.busy)
    else $error("walk not started after last entry");

  // A new result appears only when the walk hands one over
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(wst.done))
    else $error("result raised without a finished walk");

endmodule
